// ===== src/qpr_pkg.sv =====
// Shared constants of the quaternion point rotation unit.
package qpr_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

    // Quaternion component order inside the datapath.
    localparam int QC_W = 0;
    localparam int QC_X = 1;
    localparam int QC_Y = 2;
    localparam int QC_Z = 3;

    // Stage count of the front part of the datapath (products and sums).
    localparam int FRONT_STAGES = 4;

endpackage

// ===== src/qpr_div_sat.sv =====
// Pipelined restoring divider with truncation toward zero and saturation.
module qpr_div_sat
    import qpr_pkg::*;
#(
    parameter int NUM_W   = 60,
    parameter int DEN_W   = 33,
    parameter int POINT_W = 24
) (
    input  logic                      aclk,
    input  logic [POINT_W+2:0]        adv,
    input  logic signed [NUM_W-1:0]   num_in,
    input  logic [DEN_W-1:0]          den_in,
    output logic [POINT_W-1:0]        quo_out,
    output logic                      clip_out
);

    localparam int QB = POINT_W + 1;

    // First stage: sign and magnitude
    logic [NUM_W-1:0] mag0_reg;
    logic             neg0_reg;
    logic [DEN_W-1:0] den0_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            neg0_reg <= num_in[NUM_W-1];
            mag0_reg <= num_in[NUM_W-1] ? NUM_W'(-num_in) : NUM_W'(num_in);
            den0_reg <= den_in;
        end
    end

    // Bit stages: index 0 holds the overflow check, index k holds k quotient bits
    logic [NUM_W-1:0] rem_reg [QB+1];
    logic [QB-1:0]    quo_reg [QB+1];
    logic [DEN_W-1:0] den_reg [QB+1];
    logic             neg_reg [QB+1];
    logic             ovf_reg [QB+1];

    // Flag quotients that do not fit in QB bits
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            rem_reg[0] <= mag0_reg;
            quo_reg[0] <= '0;
            den_reg[0] <= den0_reg;
            neg_reg[0] <= neg0_reg;
            ovf_reg[0] <= mag0_reg >= (NUM_W'(den0_reg) << QB);
        end
    end

    // Produce one quotient bit per stage, most significant first
    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int BIT = QB - 1 - k;
        logic [NUM_W-1:0] dsh;
        logic             take;

        assign dsh  = NUM_W'(den_reg[k]) << BIT;
        assign take = rem_reg[k] >= dsh;

        always_ff @(posedge aclk) begin
            if (adv[k+2]) begin
                rem_reg[k+1] <= take ? rem_reg[k] - dsh : rem_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (take ? (QB'(1) << BIT) : QB'(0));
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // Saturate to the signed point range
    logic [QB-1:0] pos_max;
    logic [QB-1:0] neg_lim;
    logic [QB-1:0] quo_f;
    logic [QB-1:0] neg_quo;

    assign pos_max = (QB'(1) << (POINT_W - 1)) - QB'(1);
    assign neg_lim = QB'(1) << (POINT_W - 1);
    assign quo_f   = quo_reg[QB];
    assign neg_quo = QB'(0) - quo_f;

    always_comb begin
        if (neg_reg[QB]) begin
            if (ovf_reg[QB] || (quo_f > neg_lim)) begin
                quo_out  = neg_lim[POINT_W-1:0];
                clip_out = 1'b1;
            end else begin
                quo_out  = neg_quo[POINT_W-1:0];
                clip_out = 1'b0;
            end
        end else begin
            if (ovf_reg[QB] || (quo_f > pos_max)) begin
                quo_out  = pos_max[POINT_W-1:0];
                clip_out = 1'b1;
            end else begin
                quo_out  = quo_f[POINT_W-1:0];
                clip_out = 1'b0;
            end
        end
    end

endmodule

// ===== src/quaternion_point_rotation_unit.sv =====
// Top level of the quaternion point rotation unit.
//
// Rotates each incoming point p by the configured quaternion q as
// q*(p,0)*conj(q)/|q|^2 with exact integer products, division truncated
// toward zero and each coordinate saturated to POINT_WIDTH bits. One word
// enters per cycle while the output is not stalled; the pipeline has four
// product/sum stages, POINT_WIDTH+3 divider stages and one output register,
// the divider giving one quotient bit per stage. Every stage holds its word independently, so
// bubbles close up behind a stalled output. An all-zero quaternion yields
// zero coordinates with zero_quat_error set. Write the quaternion only
// while no word is in flight.
module quaternion_point_rotation_unit
    import qpr_pkg::*;
#(
    parameter int POINT_WIDTH = 24,
    parameter int QUAT_WIDTH  = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration write port
    input  logic                                      cfg_we,
    input  logic [CFG_IDX_W-1:0]                      cfg_addr,
    input  logic [QUAT_WIDTH-1:0]                     cfg_wdata,
    // input points
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // fields from bit 0: point_x, point_y, point_z, zero padding
    input  logic [((3*POINT_WIDTH+7)/8)*8-1:0]        s_tdata,
    // rotated points
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // fields from bit 0: rotated_x, rotated_y, rotated_z, zero_quat_error,
    // saturated, zero padding
    output logic [((3*POINT_WIDTH+2+7)/8)*8-1:0]      m_tdata
);

    localparam int PW     = POINT_WIDTH;
    localparam int QW     = QUAT_WIDTH;
    localparam int PROD_W = QW + PW;
    localparam int T_W    = QW + PW + 2;
    localparam int RP_W   = T_W + QW;
    localparam int NUM_W  = T_W + QW + 2;
    localparam int DEN_W  = 2 * QW + 1;
    localparam int DIV_ST = PW + 3;
    localparam int OUT_ST = FRONT_STAGES + DIV_ST;
    localparam int NST    = OUT_ST + 1;
    localparam int MD_W   = ((3*PW+2+7)/8)*8;

    // Quaternion registers
    logic signed [QW-1:0] q_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[QC_W] <= QW'(1) << (QW - 2);
            q_reg[QC_X] <= '0;
            q_reg[QC_Y] <= '0;
            q_reg[QC_Z] <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_QUAT_W: q_reg[QC_W] <= cfg_wdata;
                REG_QUAT_X: q_reg[QC_X] <= cfg_wdata;
                REG_QUAT_Y: q_reg[QC_Y] <= cfg_wdata;
                REG_QUAT_Z: q_reg[QC_Z] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Per-stage valid bits and ready chain
    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    always_comb begin
        rdy[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[NST-1];

    // Advance valid bits stage by stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 0: quaternion by point products and squares
    logic signed [PW-1:0]     pt [3];
    logic signed [PROD_W-1:0] prod_reg [4][3];
    logic [2*QW-1:0]          sq_reg [4];

    assign pt[0] = s_tdata[PW-1:0];
    assign pt[1] = s_tdata[2*PW-1:PW];
    assign pt[2] = s_tdata[3*PW-1:2*PW];

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= q_reg[i] * pt[j];
                end
                sq_reg[i] <= q_reg[i] * q_reg[i];
            end
        end
    end

    // Stage 1: t = q * (p, 0) and |q|^2
    logic signed [T_W-1:0] t_reg [4];
    logic [DEN_W-1:0]      den1_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            t_reg[QC_W] <= -prod_reg[QC_X][0] - prod_reg[QC_Y][1] - prod_reg[QC_Z][2];
            t_reg[QC_X] <=  prod_reg[QC_W][0] + prod_reg[QC_Y][2] - prod_reg[QC_Z][1];
            t_reg[QC_Y] <=  prod_reg[QC_W][1] + prod_reg[QC_Z][0] - prod_reg[QC_X][2];
            t_reg[QC_Z] <=  prod_reg[QC_W][2] + prod_reg[QC_X][1] - prod_reg[QC_Y][0];
            den1_reg    <= DEN_W'(sq_reg[0]) + DEN_W'(sq_reg[1])
                         + DEN_W'(sq_reg[2]) + DEN_W'(sq_reg[3]);
        end
    end

    // Stage 2: products of t with conj(q)
    logic signed [RP_W-1:0] rp_reg [3][4];
    logic [DEN_W-1:0]       den2_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            rp_reg[0][0] <= t_reg[QC_X] * q_reg[QC_W];
            rp_reg[0][1] <= t_reg[QC_W] * q_reg[QC_X];
            rp_reg[0][2] <= t_reg[QC_Y] * q_reg[QC_Z];
            rp_reg[0][3] <= t_reg[QC_Z] * q_reg[QC_Y];
            rp_reg[1][0] <= t_reg[QC_Y] * q_reg[QC_W];
            rp_reg[1][1] <= t_reg[QC_W] * q_reg[QC_Y];
            rp_reg[1][2] <= t_reg[QC_Z] * q_reg[QC_X];
            rp_reg[1][3] <= t_reg[QC_X] * q_reg[QC_Z];
            rp_reg[2][0] <= t_reg[QC_Z] * q_reg[QC_W];
            rp_reg[2][1] <= t_reg[QC_W] * q_reg[QC_Z];
            rp_reg[2][2] <= t_reg[QC_X] * q_reg[QC_Y];
            rp_reg[2][3] <= t_reg[QC_Y] * q_reg[QC_X];
            den2_reg     <= den1_reg;
        end
    end

    // Stage 3: numerators before division
    logic signed [NUM_W-1:0] num_reg [3];
    logic [DEN_W-1:0]        den3_reg;

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            for (int c = 0; c < 3; c++) begin
                num_reg[c] <= rp_reg[c][0] - rp_reg[c][1] - rp_reg[c][2] + rp_reg[c][3];
            end
            den3_reg <= den2_reg;
        end
    end

    // Divide and saturate each coordinate
    logic [PW-1:0] quo [3];
    logic [2:0]    clip;

    for (genvar c = 0; c < 3; c++) begin : g_div
        qpr_div_sat #(
            .NUM_W   (NUM_W),
            .DEN_W   (DEN_W),
            .POINT_W (PW)
        ) u_div (
            .aclk     (aclk),
            .adv      (rdy[FRONT_STAGES +: DIV_ST]),
            .num_in   (num_reg[c]),
            .den_in   (den3_reg),
            .quo_out  (quo[c]),
            .clip_out (clip[c])
        );
    end

    // Output register; the user must keep the quaternion stable while words are in flight (not enforced here)
    logic          q_zero;
    logic [PW-1:0] rx_reg, ry_reg, rz_reg;
    logic          err_reg, sat_reg;

    assign q_zero = (q_reg[QC_W] == '0) && (q_reg[QC_X] == '0)
                 && (q_reg[QC_Y] == '0) && (q_reg[QC_Z] == '0);

    always_ff @(posedge aclk) begin
        if (rdy[OUT_ST]) begin
            rx_reg  <= q_zero ? '0 : quo[0];
            ry_reg  <= q_zero ? '0 : quo[1];
            rz_reg  <= q_zero ? '0 : quo[2];
            err_reg <= q_zero;
            sat_reg <= !q_zero && (|clip);
        end
    end

    assign m_tdata = MD_W'({sat_reg, err_reg, rz_reg, ry_reg, rx_reg});

endmodule

// ===== tb/tb_quaternion_point_rotation_unit.sv =====
// Testbench for the quaternion point rotation unit: directed and random points against a predictor.
module tb_quaternion_point_rotation_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import qpr_pkg::*;

    localparam int PW = 24;
    localparam int QW = 16;
    localparam longint P_MAX = (64'sd1 <<< (PW - 1)) - 1;
    localparam longint P_MIN = -(64'sd1 <<< (PW - 1));

    typedef struct {
        logic signed [PW-1:0] rx;
        logic signed [PW-1:0] ry;
        logic signed [PW-1:0] rz;
        logic                 zero_err;
        logic                 sat;
    } rot_point_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [QW-1:0]         cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // point_x, point_y, point_z, zero padding
    logic [71:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // rotated_x, rotated_y, rotated_z, zero_quat_error, saturated, zero padding
    logic [79:0]           m_tdata;

    // quaternion as the predictor sees it: w, x, y, z
    logic signed [QW-1:0]  quat [4];
    rot_point_t            rotated_q [$];
    int                    fail_cnt = 0;
    int                    seen_cnt = 0;
    int                    sat_cnt = 0;
    int                    zero_cnt = 0;
    bit                    no_idle = 1'b0;
    bit                    hold_tog = 1'b0;

    quaternion_point_rotation_unit #(.POINT_WIDTH(PW), .QUAT_WIDTH(QW)) DUT (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
    );

    always #5 aclk = ~aclk;

    // clip one coordinate to the point range
    function automatic logic signed [PW-1:0] clip_coord(longint v, inout logic sat);
        if (v > P_MAX) begin
            sat = 1'b1;
            return P_MAX[PW-1:0];
        end
        if (v < P_MIN) begin
            sat = 1'b1;
            return P_MIN[PW-1:0];
        end
        return v[PW-1:0];
    endfunction

    // q * (p,0) * conj(q) / |q|^2, truncated and saturated
    function automatic rot_point_t rotate_point(logic signed [PW-1:0] px,
                                                logic signed [PW-1:0] py,
                                                logic signed [PW-1:0] pz);
        rot_point_t r;
        longint qw, qx, qy, qz, x, y, z, tw, tx, ty, tz, den;
        logic s;
        qw = quat[REG_QUAT_W]; qx = quat[REG_QUAT_X];
        qy = quat[REG_QUAT_Y]; qz = quat[REG_QUAT_Z];
        x = px; y = py; z = pz;
        s = 1'b0;
        r.zero_err = 1'b0;
        if (qw == 0 && qx == 0 && qy == 0 && qz == 0) begin
            r.rx = '0; r.ry = '0; r.rz = '0;
            r.zero_err = 1'b1; r.sat = 1'b0;
            return r;
        end
        tw = -qx * x - qy * y - qz * z;
        tx = qw * x + qy * z - qz * y;
        ty = qw * y + qz * x - qx * z;
        tz = qw * z + qx * y - qy * x;
        den = qw * qw + qx * qx + qy * qy + qz * qz;
        r.rx = clip_coord((tx * qw - tw * qx - ty * qz + tz * qy) / den, s);
        r.ry = clip_coord((ty * qw - tw * qy - tz * qx + tx * qz) / den, s);
        r.rz = clip_coord((tz * qw - tw * qz - tx * qy + ty * qx) / den, s);
        r.sat = s;
        return r;
    endfunction

    // check each rotated word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (rotated_q.size() == 0) begin
                $error("rotated word with nothing expected: %h", m_tdata);
                fail_cnt++;
            end else begin
                rot_point_t e;
                e = rotated_q.pop_front();
                seen_cnt++;
                if (e.sat) sat_cnt++;
                if (e.zero_err) zero_cnt++;
                if (m_tdata[23:0] !== e.rx) begin
                    $error("rotated_x exp %0d got %0d", e.rx, $signed(m_tdata[23:0]));
                    fail_cnt++;
                end
                if (m_tdata[47:24] !== e.ry) begin
                    $error("rotated_y exp %0d got %0d", e.ry, $signed(m_tdata[47:24]));
                    fail_cnt++;
                end
                if (m_tdata[71:48] !== e.rz) begin
                    $error("rotated_z exp %0d got %0d", e.rz, $signed(m_tdata[71:48]));
                    fail_cnt++;
                end
                if (m_tdata[72] !== e.zero_err) begin
                    $error("zero_quat_error exp %0b got %0b", e.zero_err, m_tdata[72]);
                    fail_cnt++;
                end
                if (m_tdata[73] !== e.sat) begin
                    $error("saturated exp %0b got %0b", e.sat, m_tdata[73]);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    bit hold_seen = 1'b0;
    int hold_cnt = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_cnt  <= 300;
            m_tready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 7);
        end
    end

    // offer one point word and hold it until accepted; keep the low point bits
    task automatic send_point(longint px, longint py, longint pz);
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        x = px[PW-1:0];
        y = py[PW-1:0];
        z = pz[PW-1:0];
        if (!no_idle && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rotated_q.push_back(rotate_point(x, y, z));
    endtask

    task automatic send_random_point();
        if ($urandom_range(3) == 0)
            send_point($urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
                       $urandom_range(2047) - 1024);
        else
            send_point($urandom(), $urandom(), $urandom());
    endtask

    // stop sending and wait until every rotated word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rotated_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // write all four quaternion registers while idle; keep the low component bits
    task automatic write_quat(longint w, longint x, longint y, longint z);
        logic signed [QW-1:0] v [4];
        v[REG_QUAT_W] = w[QW-1:0]; v[REG_QUAT_X] = x[QW-1:0];
        v[REG_QUAT_Y] = y[QW-1:0]; v[REG_QUAT_Z] = z[QW-1:0];
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= i[CFG_IDX_W-1:0];
            cfg_wdata <= v[i];
            @(posedge aclk);
            quat[i] = v[i];
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_identity();
        send_point(P_MAX, P_MIN, 0);
        send_point(P_MIN, P_MAX, -1);
        send_point(1, -1, 12345);
        drain();
    endtask

    task automatic test_extreme_quats();
        write_quat(-32768, -32768, -32768, -32768);
        send_point(P_MAX, P_MAX, P_MAX);
        send_point(P_MIN, P_MIN, P_MIN);
        drain();
        write_quat(32767, 32767, 32767, 32767);
        send_point(P_MIN, P_MAX, P_MIN);
        send_point(-1, -1, -1);
        drain();
        write_quat(1, 0, 0, 0);
        send_point(P_MAX, 5, -7);
        drain();
    endtask

    task automatic test_zero_quat();
        write_quat(0, 0, 0, 0);
        send_point(P_MAX, P_MIN, 99);
        send_point(0, 0, 0);
        drain();
    endtask

    // 45 degrees about z pushes a corner point out of range; then corners turn 90 degrees about z
    task automatic test_saturation();
        write_quat(15137, 0, 0, 6270);
        send_point(P_MAX, P_MAX, P_MAX);
        send_point(P_MIN, P_MIN, 0);
        send_point(P_MAX, P_MIN, 3);
        drain();
        write_quat(11585, 0, 0, 11585);
        send_point(P_MAX, P_MAX, 0);
        send_point(P_MIN, P_MAX, 0);
        drain();
    endtask

    task automatic test_random();
        for (int k = 0; k < 6; k++) begin
            if (k == 0)
                write_quat(-32768, 32767, 0, -1);
            else
                write_quat($urandom(), $urandom(), $urandom(), $urandom());
            no_idle = (k == 2);
            repeat (80) send_random_point();
            drain();
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, then sender pauses
    task automatic test_backpressure();
        write_quat($urandom(), $urandom(), $urandom(), $urandom());
        hold_tog = ~hold_tog;
        repeat (80) send_random_point();
        drain();
        repeat (40) send_random_point();
        drain();
    endtask

    initial begin
        for (int i = 0; i < 4; i++) quat[i] = '0;
        quat[REG_QUAT_W] = 16'sd16384;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_identity();
        test_extreme_quats();
        test_zero_quat();
        test_saturation();
        test_random();
        test_backpressure();
        $display("Checked %0d rotated points (%0d saturated, %0d with zero quaternion)",
                 seen_cnt, sat_cnt, zero_cnt);
        $display("over extreme, zero, reset and random quaternions with stalls.");
        if (fail_cnt == 0 && rotated_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
